FILE: rtl/core/tlds_pkg.sv
`timescale 1ns / 1ps
// tlds_pkg: types, constants and helpers for the triangle sample generator.
// No dependencies.
package tlds_pkg;

  localparam int unsigned VERT_W  = 17;  // vertex coordinate, 1.16 fixed point
  localparam int unsigned SUM_W   = 19;  // sum of three vertex coordinates
  localparam int unsigned DIVN_W  = 27;  // SUM_W + 8 fraction bits
  localparam int unsigned COORD_W = 25;  // output coordinate, 24 fraction bits
  localparam int unsigned MUL_W   = 28;
  localparam int unsigned PROD_W  = DIVN_W + MUL_W;
  localparam int unsigned DIV_SH  = 29;

  // ceil(2^29 / 3): floor(t/3) = (t * DIV3_MUL) >> 29 for t < 2^27
  localparam logic [MUL_W-1:0]   DIV3_MUL = 28'd178956971;
  localparam logic [VERT_W-1:0]  V_ONE    = 17'h10000;
  localparam logic [VERT_W-1:0]  V_ZERO   = 17'h00000;
  localparam logic [COORD_W-1:0] C_ONE    = 25'h1000000;

  localparam logic [1:0] DIG_MID = 2'd0;
  localparam logic [1:0] DIG_A   = 2'd1;
  localparam logic [1:0] DIG_B   = 2'd2;
  localparam logic [1:0] DIG_C   = 2'd3;

  typedef logic [VERT_W-1:0] vcoord_t;

  typedef struct packed {
    vcoord_t ax;
    vcoord_t ay;
    vcoord_t bx;
    vcoord_t by;
    vcoord_t cx;
    vcoord_t cy;
  } vert_t;

  localparam vert_t VERT_START = '{ax: V_ONE, ay: V_ZERO, bx: V_ZERO,
                                   by: V_ONE, cx: V_ZERO, cy: V_ZERO};

  function automatic vcoord_t mid(input vcoord_t a, input vcoord_t b);
    logic [VERT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[VERT_W:1];
  endfunction

endpackage

FILE: rtl/core/tlds_cell.sv
`timescale 1ns / 1ps
// tlds_cell: one subdivision step, picks a sub-triangle from one base-4 digit.
// Depends on tlds_pkg.
module tlds_cell import tlds_pkg::*; #(
  parameter int unsigned IDX_W = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  vert_t            vert_i,
  input  logic [IDX_W-1:0] idx_i,
  input  logic             last_i,
  output logic             valid_o,
  input  logic             ready_i,
  output vert_t            vert_o,
  output logic [IDX_W-1:0] idx_o,
  output logic             last_o
);

  logic             valid_q;
  vert_t            vert_d, vert_q;
  logic [IDX_W-1:0] idx_q;
  logic             last_q;
  logic [1:0]       digit;

  // bit-reversed index: digit msb is the lower index bit
  assign digit = {idx_i[0], idx_i[1]};

  always_comb begin
    case (digit)
      DIG_MID: begin
        vert_d.ax = mid(vert_i.bx, vert_i.cx);
        vert_d.ay = mid(vert_i.by, vert_i.cy);
        vert_d.bx = mid(vert_i.ax, vert_i.cx);
        vert_d.by = mid(vert_i.ay, vert_i.cy);
        vert_d.cx = mid(vert_i.ax, vert_i.bx);
        vert_d.cy = mid(vert_i.ay, vert_i.by);
      end
      DIG_A: begin
        vert_d.ax = vert_i.ax;
        vert_d.ay = vert_i.ay;
        vert_d.bx = mid(vert_i.ax, vert_i.bx);
        vert_d.by = mid(vert_i.ay, vert_i.by);
        vert_d.cx = mid(vert_i.ax, vert_i.cx);
        vert_d.cy = mid(vert_i.ay, vert_i.cy);
      end
      DIG_B: begin
        vert_d.ax = mid(vert_i.ax, vert_i.bx);
        vert_d.ay = mid(vert_i.ay, vert_i.by);
        vert_d.bx = vert_i.bx;
        vert_d.by = vert_i.by;
        vert_d.cx = mid(vert_i.bx, vert_i.cx);
        vert_d.cy = mid(vert_i.by, vert_i.cy);
      end
      default: begin
        vert_d.ax = mid(vert_i.ax, vert_i.cx);
        vert_d.ay = mid(vert_i.ay, vert_i.cy);
        vert_d.bx = mid(vert_i.bx, vert_i.cx);
        vert_d.by = mid(vert_i.by, vert_i.cy);
        vert_d.cx = vert_i.cx;
        vert_d.cy = vert_i.cy;
      end
    endcase
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      vert_q <= vert_d;
      idx_q  <= idx_i >> 2;
      last_q <= last_i;
    end
  end

  assign valid_o = valid_q;
  assign vert_o  = vert_q;
  assign idx_o   = idx_q;
  assign last_o  = last_q;

endmodule

FILE: rtl/core/tlds_centroid.sv
`timescale 1ns / 1ps
// tlds_centroid: centroid of the final triangle, rounded to 24 fraction bits.
// Depends on tlds_pkg.
module tlds_centroid import tlds_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  vert_t              vert_i,
  input  logic               last_i,
  output logic               valid_o,
  input  logic               ready_i,
  output logic [COORD_W-1:0] u_o,
  output logic [COORD_W-1:0] v_o,
  output logic               last_o
);

  logic               valid_q;
  logic [SUM_W-1:0]   sx, sy;
  logic [DIVN_W-1:0]  tx, ty;
  logic [PROD_W-1:0]  px, py;
  logic [COORD_W-1:0] u_q, v_q;
  logic               last_q;

  assign sx = SUM_W'(vert_i.ax) + SUM_W'(vert_i.bx) + SUM_W'(vert_i.cx);
  assign sy = SUM_W'(vert_i.ay) + SUM_W'(vert_i.by) + SUM_W'(vert_i.cy);
  // S*256 + 1, then floor(/3) gives round to nearest
  assign tx = {sx, 8'h01};
  assign ty = {sy, 8'h01};
  assign px = PROD_W'(tx) * PROD_W'(DIV3_MUL);
  assign py = PROD_W'(ty) * PROD_W'(DIV3_MUL);

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      u_q    <= px[DIV_SH +: COORD_W];
      v_q    <= py[DIV_SH +: COORD_W];
      last_q <= last_i;
    end
  end

  assign valid_o = valid_q;
  assign u_o     = u_q;
  assign v_o     = v_q;
  assign last_o  = last_q;

endmodule

FILE: rtl/core/triangle_low_discrepancy_sample_top.sv
`timescale 1ns / 1ps
// triangle_low_discrepancy_sample_top: low-discrepancy points over a triangle.
// Depends on tlds_pkg, tlds_cell, tlds_centroid.

// Takes one sample index per cycle and returns its barycentric coordinates
// (u, v, w) with 24 fraction bits, one result per item, in order. The index
// is read as DIGITS base-4 digits of the bit reversal of its low 2*DIGITS
// bits; a row of DIGITS subdivision cells each applies one digit, then a
// centroid stage (one constant multiply per coordinate) and an output
// register follow. Throughput is one item per cycle while the output is not
// stalled. tready is a combinational chain back through the row of cells, so
// a stalled output only holds the input once every stage is full.
module triangle_low_discrepancy_sample_top import tlds_pkg::*; #(
  parameter int unsigned DIGITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] sample_index
  input  logic        s_axis_tlast,   // last_sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // [24:0] coord_u, [49:25] coord_v,
                                      // [74:50] coord_w, [79:75] zero
  output logic        m_axis_tlast    // last_out
);

  localparam int unsigned IDX_W = 2 * DIGITS;

  logic             c_valid [DIGITS+1];
  logic             c_ready [DIGITS+1];
  vert_t            c_vert  [DIGITS+1];
  logic [IDX_W-1:0] c_idx   [DIGITS+1];
  logic             c_last  [DIGITS+1];

  assign c_valid[0]    = s_axis_tvalid;
  assign s_axis_tready = c_ready[0];
  assign c_vert[0]     = VERT_START;
  assign c_idx[0]      = s_axis_tdata[IDX_W-1:0];
  assign c_last[0]     = s_axis_tlast;

  for (genvar g = 0; g < DIGITS; g++) begin : g_cell
    tlds_cell #(.IDX_W(IDX_W)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (c_valid[g]),
      .ready_o (c_ready[g]),
      .vert_i  (c_vert[g]),
      .idx_i   (c_idx[g]),
      .last_i  (c_last[g]),
      .valid_o (c_valid[g+1]),
      .ready_i (c_ready[g+1]),
      .vert_o  (c_vert[g+1]),
      .idx_o   (c_idx[g+1]),
      .last_o  (c_last[g+1])
    );
  end

  logic               cen_valid, cen_last;
  logic [COORD_W-1:0] cen_u, cen_v;
  logic               out_ready;

  tlds_centroid u_centroid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (c_valid[DIGITS]),
    .ready_o (c_ready[DIGITS]),
    .vert_i  (c_vert[DIGITS]),
    .last_i  (c_last[DIGITS]),
    .valid_o (cen_valid),
    .ready_i (out_ready),
    .u_o     (cen_u),
    .v_o     (cen_v),
    .last_o  (cen_last)
  );

  logic [COORD_W:0]   uv_sum;
  logic [COORD_W-1:0] w_d;
  logic               valid_q, last_q;
  logic [COORD_W-1:0] u_q, v_q, w_q;

  assign uv_sum = {1'b0, cen_u} + {1'b0, cen_v};
  assign w_d    = (uv_sum >= (COORD_W+1)'(C_ONE)) ? '0
                : COORD_W'((COORD_W+1)'(C_ONE) - uv_sum);

  assign out_ready = !valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (out_ready) begin
      valid_q <= cen_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && cen_valid) begin
      u_q    <= cen_u;
      v_q    <= cen_v;
      w_q    <= w_d;
      last_q <= cen_last;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {5'b0, w_q, v_q, u_q};
  assign m_axis_tlast  = last_q;

endmodule

FILE: rtl/core/tlds_checker.sv
`timescale 1ns / 1ps
// tlds_checker: port-level checks for triangle_low_discrepancy_sample_top.
// Bound to the top level below; watches its ports only.
module tlds_checker #(
  parameter int unsigned DIGITS = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [79:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  localparam int unsigned DEPTH = DIGITS + 2;
  localparam int unsigned CNT_W = $clog2(DEPTH + 2);

  logic [CNT_W-1:0] inflight_q;
  logic             acc_in, acc_out;
  logic [25:0]      coord_sum;

  assign acc_in    = s_axis_tvalid && s_axis_tready;
  assign acc_out   = m_axis_tvalid && m_axis_tready;
  assign coord_sum = 26'(m_axis_tdata[24:0]) + 26'(m_axis_tdata[49:25])
                   + 26'(m_axis_tdata[74:50]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else if (acc_in && !acc_out) begin
      inflight_q <= inflight_q + CNT_W'(1);
    end else if (acc_out && !acc_in) begin
      inflight_q <= inflight_q - CNT_W'(1);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                        && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> inflight_q != '0)
    else $error("result shown with no item in flight");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= CNT_W'(DEPTH))
    else $error("more items in flight than pipeline stages");

  a_w_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[74:50] == 25'd0 || coord_sum == 26'h1000000)
                      && m_axis_tdata[79:75] == 5'd0)
    else $error("u + v + w does not close to one");

endmodule

bind triangle_low_discrepancy_sample_top tlds_checker #(.DIGITS(DIGITS)) u_tlds_checker (.*);
